### rtl/mm16_pkg.sv
// Shared types and constants for the mini MIPS16 execute unit.
// Used by every module under rtl/; depends on nothing else.
package mm16_pkg;

    localparam int WORD_W      = 16;
    localparam int PC_W        = 12;
    localparam int REG_IDX_W   = 3;
    localparam int REG_COUNT   = 8;
    localparam int DATA_DEPTH  = 256;
    localparam int DADDR_W     = $clog2(DATA_DEPTH);
    localparam int IMM_W       = 6;
    localparam int PLEN_W      = 9;
    localparam int OP_W        = 4;
    localparam int FUNCT_W     = 3;
    localparam int INSTR_W     = 16;
    localparam int OUT_ADDR_W  = 8;
    localparam int OUT_USED_W  = PC_W + 3 + REG_IDX_W + WORD_W + 1 + OUT_ADDR_W + WORD_W + 1;
    localparam int M_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [WORD_W-1:0] REG_RESET_VAL = WORD_W'(10);

    localparam logic [OP_W-1:0] OP_RTYPE = 4'd0;
    localparam logic [OP_W-1:0] OP_ADDI  = 4'd1;
    localparam logic [OP_W-1:0] OP_SUBI  = 4'd2;
    localparam logic [OP_W-1:0] OP_LW    = 4'd3;
    localparam logic [OP_W-1:0] OP_SW    = 4'd4;
    localparam logic [OP_W-1:0] OP_BEQ   = 4'd5;
    localparam logic [OP_W-1:0] OP_JUMP  = 4'd8;

    localparam logic [FUNCT_W-1:0] FN_ADD = 3'd0;
    localparam logic [FUNCT_W-1:0] FN_SUB = 3'd1;
    localparam logic [FUNCT_W-1:0] FN_AND = 3'd2;
    localparam logic [FUNCT_W-1:0] FN_OR  = 3'd3;

    typedef struct packed {
        logic [PC_W-1:0]      pc_next;
        logic                 halted;
        logic                 invalid;
        logic                 reg_write;
        logic [REG_IDX_W-1:0] reg_index;
        logic [WORD_W-1:0]    reg_value;
        logic                 mem_write;
        logic                 mem_read;
        logic [DADDR_W-1:0]   mem_address;
        logic [WORD_W-1:0]    mem_value;
        logic                 taken;
    } exec_res_t;

endpackage

### rtl/mm16_regfile.sv
// Register file: synchronous memory with two read ports and one write port.
// Valid bits supply the reset value; a same-edge write is forwarded to the reads.
// Depends on mm16_pkg.
module mm16_regfile (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [mm16_pkg::REG_IDX_W-1:0]  rd_addr_a,
    input  logic [mm16_pkg::REG_IDX_W-1:0]  rd_addr_b,
    input  logic                            wr_en,
    input  logic [mm16_pkg::REG_IDX_W-1:0]  wr_addr,
    input  logic [mm16_pkg::WORD_W-1:0]     wr_data,
    output logic [mm16_pkg::WORD_W-1:0]     rd_data_a,
    output logic [mm16_pkg::WORD_W-1:0]     rd_data_b
);
    import mm16_pkg::*;

    logic [WORD_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [WORD_W-1:0]    rd_a_reg;
    logic [WORD_W-1:0]    rd_b_reg;
    logic [WORD_W-1:0]    byp_reg;
    logic                 a_vld_reg;
    logic                 b_vld_reg;
    logic                 a_fwd_reg;
    logic                 b_fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
            byp_reg  <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            a_fwd_reg <= 1'b0;
            b_fwd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                a_vld_reg <= vld_reg[rd_addr_a];
                b_vld_reg <= vld_reg[rd_addr_b];
                // memory returns old data on a same-edge write: take the write data
                a_fwd_reg <= wr_en && (wr_addr == rd_addr_a);
                b_fwd_reg <= wr_en && (wr_addr == rd_addr_b);
            end
        end
    end

    assign rd_data_a = a_fwd_reg ? byp_reg : (a_vld_reg ? rd_a_reg : REG_RESET_VAL);
    assign rd_data_b = b_fwd_reg ? byp_reg : (b_vld_reg ? rd_b_reg : REG_RESET_VAL);

endmodule

### rtl/mm16_dmem.sv
// Data memory: single-port synchronous memory with registered read data.
// Per-entry valid bits make unwritten words read as zero. Depends on mm16_pkg.
module mm16_dmem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          we,
    input  logic [mm16_pkg::DADDR_W-1:0]  addr,
    input  logic [mm16_pkg::WORD_W-1:0]   wdata,
    output logic [mm16_pkg::WORD_W-1:0]   rd_data
);
    import mm16_pkg::*;

    logic [WORD_W-1:0]     mem [DATA_DEPTH];
    logic [DATA_DEPTH-1:0] vld_reg;
    logic [WORD_W-1:0]     q_reg;
    logic                  q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
        if (en)
        begin
            q_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            if (we)
            begin
                vld_reg[addr] <= 1'b1;
            end
            q_vld_reg <= vld_reg[addr];
        end
    end

    assign rd_data = q_vld_reg ? q_reg : '0;

endmodule

### rtl/mm16_exec.sv
// Decode and execute stage: ALU, address adder, branch compare and next PC.
// Purely combinational. Depends on mm16_pkg.
module mm16_exec (
    input  logic [mm16_pkg::INSTR_W-1:0] instr,
    input  logic [mm16_pkg::WORD_W-1:0]  op_a,
    input  logic [mm16_pkg::WORD_W-1:0]  op_b,
    input  logic [mm16_pkg::PC_W-1:0]    pc,
    input  logic [mm16_pkg::PLEN_W-1:0]  prog_len,
    output mm16_pkg::exec_res_t          res
);
    import mm16_pkg::*;

    logic [OP_W-1:0]      opcode;
    logic [REG_IDX_W-1:0] rt;
    logic [REG_IDX_W-1:0] rd;
    logic [FUNCT_W-1:0]   funct;
    logic [IMM_W-1:0]     imm6;
    logic [WORD_W-1:0]    imm_w;
    logic [PC_W-1:0]      imm_pc;
    logic [WORD_W-1:0]    sum;
    logic [WORD_W-1:0]    diff;
    logic [PC_W-1:0]      pc_inc;

    assign opcode = instr[15:12];
    assign rt     = instr[8:6];
    assign rd     = instr[5:3];
    assign funct  = instr[2:0];
    assign imm6   = instr[5:0];
    assign imm_w  = {{(WORD_W-IMM_W){imm6[IMM_W-1]}}, imm6};
    assign imm_pc = {{(PC_W-IMM_W){imm6[IMM_W-1]}}, imm6};
    assign sum    = op_a + imm_w;
    assign diff   = op_a - imm_w;
    assign pc_inc = pc + PC_W'(1);

    always_comb
    begin
        res         = '0;
        res.pc_next = pc_inc;
        priority if (pc >= PC_W'(prog_len))
        begin
            res.halted  = 1'b1;
            res.pc_next = pc;
        end
        else
        begin
            unique case (opcode)
                OP_RTYPE:
                begin
                    res.reg_write = 1'b1;
                    res.reg_index = rd;
                    unique case (funct)
                        FN_ADD:  res.reg_value = op_a + op_b;
                        FN_SUB:  res.reg_value = op_a - op_b;
                        FN_AND:  res.reg_value = op_a & op_b;
                        FN_OR:   res.reg_value = op_a | op_b;
                        default: res.reg_value = '0;
                    endcase
                end
                OP_ADDI:
                begin
                    res.reg_write = 1'b1;
                    res.reg_index = rt;
                    res.reg_value = sum;
                end
                OP_SUBI:
                begin
                    res.reg_write = 1'b1;
                    res.reg_index = rt;
                    res.reg_value = diff;
                end
                OP_LW:
                begin
                    // value arrives from data memory in the result stage
                    res.reg_write   = 1'b1;
                    res.reg_index   = rt;
                    res.mem_read    = 1'b1;
                    res.mem_address = sum[DADDR_W-1:0];
                end
                OP_SW:
                begin
                    res.mem_write   = 1'b1;
                    res.mem_address = sum[DADDR_W-1:0];
                    res.mem_value   = op_b;
                end
                OP_BEQ:
                begin
                    if (op_a == op_b)
                    begin
                        res.taken   = 1'b1;
                        res.pc_next = pc_inc + imm_pc;
                    end
                end
                OP_JUMP:
                begin
                    res.taken   = 1'b1;
                    res.pc_next = instr[PC_W-1:0];
                end
                default:
                begin
                    res.invalid = 1'b1;
                end
            endcase
        end
    end

endmodule

### rtl/mini_mips16_execute_unit.sv
// Mini MIPS16 execute unit: two-stage pipeline (register read and execute, result).
// The instruction is registered in the register read and execute stage and its result in the
// output stage; throughput one instruction per cycle with no backpressure.
// Results stall in the output stage under backpressure while the next instruction waits.
// Reset (async, active low) sets PC and program length to zero, registers to ten and
// data memory to zero at once through valid bits; no clearing pass is needed.
module mini_mips16_execute_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mm16_pkg::INSTR_W-1:0]      s_tdata,   // instruction_word
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pc_after, halted, invalid_instruction, reg_write, reg_index, reg_value,
    // mem_write, mem_address, mem_value, branch_taken, zero pad
    output logic [mm16_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [mm16_pkg::PLEN_W-1:0]       cfg_wdata   // program_length
);
    import mm16_pkg::*;

    logic                  s1_valid_reg;
    logic [INSTR_W-1:0]    s1_instr_reg;
    logic                  s2_valid_reg;
    exec_res_t             s2_res_reg;
    logic [PC_W-1:0]       pc_reg;
    logic [PLEN_W-1:0]     plen_reg;

    logic                  s2_free;
    logic                  s1_move;
    logic                  accept;
    logic [WORD_W-1:0]     rf_a;
    logic [WORD_W-1:0]     rf_b;
    logic [WORD_W-1:0]     op_a;
    logic [WORD_W-1:0]     op_b;
    logic [WORD_W-1:0]     ld_data;
    logic [WORD_W-1:0]     s2_wval;
    logic                  rf_we;
    logic                  fwd_a;
    logic                  fwd_b;
    exec_res_t             ex_res;

    assign s2_free  = !s2_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s2_free;
    assign accept   = s_tvalid && s_tready;

    assign s2_wval = s2_res_reg.mem_read ? ld_data : s2_res_reg.reg_value;
    assign rf_we   = s2_valid_reg && m_tready && s2_res_reg.reg_write;

    // forward the pending write of the result stage into execute
    assign fwd_a = s2_valid_reg && s2_res_reg.reg_write &&
                   (s2_res_reg.reg_index == s1_instr_reg[11:9]);
    assign fwd_b = s2_valid_reg && s2_res_reg.reg_write &&
                   (s2_res_reg.reg_index == s1_instr_reg[8:6]);
    assign op_a  = fwd_a ? s2_wval : rf_a;
    assign op_b  = fwd_b ? s2_wval : rf_b;

    mm16_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (s_tdata[11:9]),
        .rd_addr_b (s_tdata[8:6]),
        .wr_en     (rf_we),
        .wr_addr   (s2_res_reg.reg_index),
        .wr_data   (s2_wval),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    mm16_exec u_exec (
        .instr    (s1_instr_reg),
        .op_a     (op_a),
        .op_b     (op_b),
        .pc       (pc_reg),
        .prog_len (plen_reg),
        .res      (ex_res)
    );

    mm16_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (s1_move),
        .we      (ex_res.mem_write),
        .addr    (ex_res.mem_address),
        .wdata   (ex_res.mem_value),
        .rd_data (ld_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= s_tdata;
        end
        if (s1_move)
        begin
            s2_res_reg <= ex_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pc_reg       <= '0;
            plen_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                pc_reg <= ex_res.pc_next;
            end
            if (cfg_we)
            begin
                plen_reg <= cfg_wdata;
            end
        end
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_USED_W){1'b0}},
                       s2_res_reg.taken,
                       s2_res_reg.mem_value,
                       OUT_ADDR_W'(s2_res_reg.mem_address),
                       s2_res_reg.mem_write,
                       s2_wval,
                       s2_res_reg.reg_index,
                       s2_res_reg.reg_write,
                       s2_res_reg.invalid,
                       s2_res_reg.halted,
                       s2_res_reg.pc_next};

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_res_reg.halted) |->
        (!s2_res_reg.reg_write && !s2_res_reg.mem_write && !s2_res_reg.taken))
        else $error("halted result carries side effects");

    a_pc_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && !ex_res.halted && !ex_res.taken) |=>
        (pc_reg == $past(pc_reg) + PC_W'(1)))
        else $error("sequential PC did not advance by one");

    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && ex_res.halted) |=> $stable(pc_reg))
        else $error("PC moved on a halted step");

    a_ld_st_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !(s2_res_reg.mem_read && s2_res_reg.mem_write))
        else $error("load and store in the same result");

endmodule

### verif/exec_result_checker.sv
// Result checker for the mini MIPS16 execute unit: keeps its own copy of the
// register file, data memory, PC and program length and compares every result transfer.
// Depends on mm16_pkg for widths, reset value and opcode/funct constants.
module exec_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mm16_pkg::INSTR_W-1:0]   s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mm16_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic [mm16_pkg::PLEN_W-1:0]    cfg_wdata,
    output int                             mismatches,
    output int                             results_owed,
    output logic [mm16_pkg::PC_W-1:0]      next_fetch_pc
);
    timeunit 1ns;
    timeprecision 1ps;

    import mm16_pkg::*;

    // result fields, first field in the top bits so the struct matches m_tdata
    typedef struct packed {
        logic                  taken;
        logic [WORD_W-1:0]     mem_value;
        logic [OUT_ADDR_W-1:0] mem_address;
        logic                  mem_write;
        logic [WORD_W-1:0]     reg_value;
        logic [REG_IDX_W-1:0]  reg_index;
        logic                  reg_write;
        logic                  invalid;
        logic                  halted;
        logic [PC_W-1:0]       pc_after;
    } step_result_t;

    logic [WORD_W-1:0] gpr [REG_COUNT];
    logic [WORD_W-1:0] dmem [DATA_DEPTH];
    logic [PC_W-1:0]   pc;
    logic [PLEN_W-1:0] prog_len;
    step_result_t      owed_q [$];

    function automatic step_result_t execute_instr(input logic [INSTR_W-1:0] w);
        step_result_t      r;
        logic [OP_W-1:0]   op;
        logic [2:0]        rs;
        logic [2:0]        rt;
        logic [WORD_W-1:0] imm;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] sum;
        logic [PC_W-1:0]   nxt;
        op  = w[15:12];
        rs  = w[11:9];
        rt  = w[8:6];
        imm = {{(WORD_W-IMM_W){w[5]}}, w[5:0]};
        a   = gpr[rs];
        b   = gpr[rt];
        sum = a + imm;
        r   = '0;
        nxt = pc + 12'd1;
        if (pc >= prog_len)
        begin
            // past the program: hold the PC, report nothing else
            r.halted = 1'b1;
            nxt = pc;
        end
        else
        begin
            case (op)
                OP_RTYPE:
                begin
                    r.reg_write = 1'b1;
                    r.reg_index = w[5:3];
                    case (w[2:0])
                        FN_ADD:  r.reg_value = a + b;
                        FN_SUB:  r.reg_value = a - b;
                        FN_AND:  r.reg_value = a & b;
                        FN_OR:   r.reg_value = a | b;
                        default: r.reg_value = '0;
                    endcase
                end
                OP_ADDI, OP_SUBI:
                begin
                    r.reg_write = 1'b1;
                    r.reg_index = rt;
                    r.reg_value = (op == OP_ADDI) ? sum : a - imm;
                end
                OP_LW:
                begin
                    r.mem_address = sum[OUT_ADDR_W-1:0];
                    r.reg_write   = 1'b1;
                    r.reg_index   = rt;
                    r.reg_value   = dmem[r.mem_address];
                end
                OP_SW:
                begin
                    r.mem_address = sum[OUT_ADDR_W-1:0];
                    r.mem_write   = 1'b1;
                    r.mem_value   = b;
                    dmem[r.mem_address] = b;
                end
                OP_BEQ:
                begin
                    if (a == b)
                    begin
                        r.taken = 1'b1;
                        nxt = pc + 12'd1 + imm[PC_W-1:0];
                    end
                end
                OP_JUMP:
                begin
                    r.taken = 1'b1;
                    nxt = w[PC_W-1:0];
                end
                default: r.invalid = 1'b1;
            endcase
        end
        if (r.reg_write)
            gpr[r.reg_index] = r.reg_value;
        pc = nxt;
        r.pc_after = nxt;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [WORD_W-1:0] want_v,
                               input logic [WORD_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", fname, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        step_result_t got;
        step_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                gpr[i] = REG_RESET_VAL;
            for (int i = 0; i < DATA_DEPTH; i++)
                dmem[i] = '0;
            pc = '0;
            prog_len = '0;
            owed_q.delete();
            mismatches = 0;
        end
        else
        begin
            // compare before predicting: a result never belongs to the same-edge transfer
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(step_result_t)-1:0];
                if (owed_q.size() == 0)
                begin
                    $error("result transfer with nothing outstanding, pc_after 0x%0h",
                           got.pc_after);
                    mismatches++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("pc_after", want.pc_after, got.pc_after);
                    check_field("halted", want.halted, got.halted);
                    check_field("invalid_instruction", want.invalid, got.invalid);
                    check_field("reg_write", want.reg_write, got.reg_write);
                    check_field("reg_index", want.reg_index, got.reg_index);
                    check_field("reg_value", want.reg_value, got.reg_value);
                    check_field("mem_write", want.mem_write, got.mem_write);
                    check_field("mem_address", want.mem_address, got.mem_address);
                    check_field("mem_value", want.mem_value, got.mem_value);
                    check_field("branch_taken", want.taken, got.taken);
                end
            end
            if (cfg_we)
                prog_len = cfg_wdata;
            if (s_tvalid && s_tready)
                owed_q.push_back(execute_instr(s_tdata));
        end
        results_owed  = owed_q.size();
        next_fetch_pc = pc;
    end

endmodule

### verif/tb.sv
// Top of the execute unit testbench: clock, reset, instruction stimulus and flow control.
// Depends on mm16_pkg, the mini_mips16_execute_unit RTL and exec_result_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mm16_pkg::*;

    localparam int PROG_MAX    = 256;
    localparam int PC_MARGIN   = 34;
    localparam int HOLD_CYCLES = 64;
    localparam int CYCLE_LIMIT = 100000;
    localparam logic [OP_W-1:0] OP_SPARE = 4'd10;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [INSTR_W-1:0]   s_tdata   = '0;   // instruction_word
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // pc_after, halted, invalid_instruction, reg_write, reg_index, reg_value,
    // mem_write, mem_address, mem_value, branch_taken, zero pad
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [PLEN_W-1:0]    cfg_wdata = '0;   // program_length

    int                   mismatches;
    int                   results_owed;
    logic [PC_W-1:0]      next_fetch_pc;

    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   plen_val       = 0;
    logic                 hold_toggle    = 1'b0;
    logic                 hold_seen      = 1'b0;
    int                   hold_left      = 0;
    int                   cycles         = 0;
    logic [INSTR_W-1:0]   last_store     = '0;

    mini_mips16_execute_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    exec_result_checker result_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .results_owed  (results_owed),
        .next_fetch_pc (next_fetch_pc)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [INSTR_W-1:0] enc_r(input logic [2:0] rs, input logic [2:0] rt,
                                                 input logic [2:0] rd,
                                                 input logic [FUNCT_W-1:0] fn);
        return {OP_RTYPE, rs, rt, rd, fn};
    endfunction

    function automatic logic [INSTR_W-1:0] enc_i(input logic [OP_W-1:0] op,
                                                 input logic [2:0] rs, input logic [2:0] rt,
                                                 input logic [IMM_W-1:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [INSTR_W-1:0] enc_j(input logic [PC_W-1:0] target);
        return {OP_JUMP, target};
    endfunction

    // Random instruction that keeps the PC inside the program.
    function automatic logic [INSTR_W-1:0] pick_instr();
        logic [INSTR_W-1:0] w;
        int                 sel;
        w   = INSTR_W'($urandom);
        sel = $urandom_range(99);
        // near either end of the program a branch could leave it: jump back inside
        if (int'(next_fetch_pc) < PC_MARGIN - 1 || int'(next_fetch_pc) + PC_MARGIN >= plen_val)
            w[15:12] = OP_JUMP;
        else if (sel < 30)
            w[15:12] = OP_RTYPE;
        else if (sel < 42)
            w[15:12] = OP_ADDI;
        else if (sel < 50)
            w[15:12] = OP_SUBI;
        else if (sel < 62)
        begin
            w[15:12] = OP_LW;
            // reuse the last store address so loads often hit written words
            if ($urandom_range(1) == 1)
                w = {OP_LW, last_store[11:9], w[8:6], last_store[5:0]};
        end
        else if (sel < 74)
            w[15:12] = OP_SW;
        else if (sel < 84)
        begin
            w[15:12] = OP_BEQ;
            if ($urandom_range(1) == 1)
                w[8:6] = w[11:9];
        end
        else if (sel < 90)
            w[15:12] = OP_JUMP;
        if (w[15:12] == OP_JUMP)
            w[11:0] = PC_W'($urandom_range(plen_val - 1, 0));
        if (w[15:12] == OP_SW)
            last_store = w;
        return w;
    endfunction

    task automatic send_instr(input logic [INSTR_W-1:0] w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // drop valid and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    task automatic write_plen(input int v);
        cfg_we    <= 1'b1;
        cfg_wdata <= PLEN_W'(v);
        @(negedge clk);
        cfg_we   <= 1'b0;
        plen_val = v;
    endtask

    // Jump to start_pc, shrink the program to run_len instructions from there, run past its end.
    task automatic run_halt(input int start_pc, input int run_len);
        logic [INSTR_W-1:0] w;
        send_instr(enc_j(PC_W'(start_pc)));
        drain();
        write_plen(start_pc + run_len);
        for (int i = 0; i < run_len + 3; i++)
        begin
            w = INSTR_W'($urandom);
            // the executed ones must advance sequentially to reach the end
            if (i < run_len && (w[15:12] == OP_BEQ || w[15:12] == OP_JUMP))
                w[15:12] = OP_SPARE;
            send_instr(w);
        end
        drain();
        write_plen(PROG_MAX);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                              input int lim, input bit with_holdoff);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_instr(enc_j(12'd64));
        drain();
        write_plen(lim);
        for (int i = 0; i < count; i++)
        begin
            if (with_holdoff && i == count / 3)
                hold_toggle <= ~hold_toggle;
            send_instr(pick_instr());
        end
        drain();
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty program: everything halts at PC zero
        write_plen(0);
        send_instr(16'hFFFF);
        send_instr(16'h0000);
        drain();

        write_plen(PROG_MAX);
        send_instr(enc_i(OP_ADDI, 3'd1, 3'd1, 6'd31));
        send_instr(enc_i(OP_ADDI, 3'd2, 3'd2, 6'h20));
        send_instr(enc_r(3'd1, 3'd2, 3'd3, FN_ADD));
        send_instr(enc_r(3'd2, 3'd1, 3'd4, FN_SUB));
        send_instr(enc_r(3'd1, 3'd4, 3'd5, FN_AND));
        send_instr(enc_r(3'd1, 3'd4, 3'd6, FN_OR));
        send_instr(enc_r(3'd1, 3'd2, 3'd7, 3'd4));
        send_instr(enc_r(3'd1, 3'd2, 3'd0, 3'd7));
        send_instr(enc_i(OP_SUBI, 3'd0, 3'd0, 6'h3F));
        send_instr(enc_i(OP_SUBI, 3'd4, 3'd7, 6'd31));
        send_instr(enc_r(3'd7, 3'd7, 3'd2, FN_ADD));
        // negative base plus negative offset: address wraps into the top of memory
        send_instr(enc_i(OP_SW, 3'd7, 3'd1, 6'h20));
        send_instr(enc_i(OP_LW, 3'd7, 3'd3, 6'h20));
        send_instr(enc_i(OP_LW, 3'd1, 3'd5, 6'd0));
        send_instr(enc_i(OP_SW, 3'd0, 3'd4, 6'd0));
        send_instr(enc_i(OP_BEQ, 3'd1, 3'd1, 6'd3));
        send_instr(enc_i(OP_BEQ, 3'd1, 3'd2, 6'd5));
        send_instr(enc_j(12'd200));
        send_instr(enc_i(OP_BEQ, 3'd6, 3'd6, 6'h20));
        send_instr(16'h6FFF);
        send_instr(16'h7000);
        send_instr(16'h9ABC);
        send_instr(16'hF123);
        drain();

        run_halt(0, 1);
        run_halt($urandom_range(250, 100), 2);

        run_random(200, 0, 0, PROG_MAX, 1'b1);
        run_random(200, 54, 0, $urandom_range(255, 120), 1'b0);
        run_random(200, 0, 54, PROG_MAX, 1'b0);
        run_random(200, 17, 17, $urandom_range(255, 120), 1'b0);

        // taken branch below address zero wraps the PC far past the program
        send_instr(enc_j(12'd2));
        send_instr(enc_i(OP_BEQ, 3'd3, 3'd3, 6'h20));
        repeat (2) send_instr(INSTR_W'($urandom));
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/mm16_pkg.sv
rtl/mm16_regfile.sv
rtl/mm16_dmem.sv
rtl/mm16_exec.sv
rtl/mini_mips16_execute_unit.sv
verif/exec_result_checker.sv
verif/tb.sv
